// ===== hw/rtl/tqps_pkg.sv =====
`timescale 1ns / 1ps
package tqps_pkg;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_CREATE = 3'd1;
  localparam logic [2:0] MODE_BLOCK  = 3'd2;
  localparam logic [2:0] MODE_WAKE   = 3'd3;
  localparam logic [2:0] MODE_REMOVE = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RUN_EMPTY = 3'd1;
  localparam logic [2:0] ST_WAIT_EMPT = 3'd2;
  localparam logic [2:0] ST_RUN_FULL  = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_Q_FULL    = 3'd5;

  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_RR   = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;
  localparam logic [1:0] POL_SRT  = 2'd3;

  localparam logic [1:0] REG_POLICY  = 2'd0;
  localparam logic [1:0] REG_SLICE   = 2'd1;
  localparam logic [1:0] REG_RUN_CAP = 2'd2;
  localparam logic [1:0] REG_REFILL  = 2'd3;

  localparam logic [5:0] RUN_CAP_RST = 6'd20;
  localparam logic [5:0] REFILL_RST  = 6'd5;

  // Result beat returned by one operation.
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] new_id;
    logic        retired;
    logic [15:0] retired_id;
    logic [15:0] head_id;
    logic [5:0]  run_level;
    logic [5:0]  wait_level;
  } result_t;

endpackage

// ===== hw/rtl/tqps_ram.sv =====
`timescale 1ns / 1ps
module tqps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/two_queue_process_scheduler_top.sv =====
`timescale 1ns / 1ps
// Two-queue process scheduler.
// Input channel: in_valid_i / in_stall_o carry one operation per beat
// (mode, burst_time, priority_level, proc_id). A beat is taken when valid
// is high and stall is low. Output channel: out_valid_o / out_stall_i
// carry one result beat per operation, in order.
// Configuration: cfg_valid_i / cfg_ready_o with cfg_index_i and
// cfg_data_i; ready only while idle with no result pending.
// Operation is sequential: one sequencer walks both queues through one
// registered RAM read port per queue. Search issues a read and then compares
// each entry visited; compaction reads entry idx+1 and then writes it at idx.
// A sort pass reads its key, then reads and compares each neighbour j-1,
// shifting it up one place until the key lands. Priority and shortest-time
// policies sort both queues before and after every operation (four passes);
// first come and round robin skip the sort, so a tick costs its top-up
// and compaction walks. The input is stalled until the result is loaded into
// the output register; a stalled receiver holds the sequencer at its last
// step, so a new beat may be taken while a result waits.
// Reset clears occupancies, id counter and registers; queue storage is
// not cleared, only entries below an occupancy are ever read.
module two_queue_process_scheduler_top
  import tqps_pkg::*;
#(
  parameter int RUN_DEPTH  = 32,
  parameter int WAIT_DEPTH = 32,
  parameter int ID_BITS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  mode_i,
  input  logic [15:0] burst_time_i,
  input  logic [3:0]  priority_level_i,
  input  logic [15:0] proc_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] new_id_o,
  output logic        retired_o,
  output logic [15:0] retired_id_o,
  output logic [15:0] head_id_o,
  output logic [5:0]  run_level_o,
  output logic [5:0]  wait_level_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  localparam int RA = $clog2(RUN_DEPTH);
  localparam int WA = $clog2(WAIT_DEPTH);
  localparam int CW = (RA > WA ? RA : WA) + 1;
  localparam int CMPW = (CW > 6) ? CW : 6;
  localparam int EW = ID_BITS + 16 + 16 + 4;

  // Entry layout: {id, burst, left, prio}
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [15:0]        burst;
    logic [15:0]        left;
    logic [3:0]         prio;
  } entry_t;

  // Sequencer states
  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_SORT   = 5'd1;  // insertion sort, pick key
  localparam logic [4:0] S_SRTK   = 5'd2;  // key read lands
  localparam logic [4:0] S_SRTR   = 5'd3;  // read neighbour j-1
  localparam logic [4:0] S_SRTC   = 5'd4;  // compare and shift
  localparam logic [4:0] S_DISP   = 5'd5;
  localparam logic [4:0] S_FIND   = 5'd6;  // issue read at idx
  localparam logic [4:0] S_FINDC  = 5'd7;  // compare
  localparam logic [4:0] S_SHR    = 5'd8;  // compact: read idx+1
  localparam logic [4:0] S_SHW    = 5'd9;  // compact: write idx
  localparam logic [4:0] S_APP    = 5'd10; // append held entry
  localparam logic [4:0] S_TOPR   = 5'd11; // read wait head
  localparam logic [4:0] S_TOPW   = 5'd12;
  localparam logic [4:0] S_HEADR  = 5'd13; // read run head
  localparam logic [4:0] S_HEADW  = 5'd14;
  localparam logic [4:0] S_POST   = 5'd15; // post-operation sort or finish
  localparam logic [4:0] S_HIDR   = 5'd16; // read head id for result
  localparam logic [4:0] S_HIDW   = 5'd17;
  localparam logic [4:0] S_DONE   = 5'd18;
  localparam logic [4:0] S_SRTW   = 5'd19; // key lands at slot 0

  // Compaction follow-up actions
  localparam logic [2:0] NX_NONE    = 3'd0;
  localparam logic [2:0] NX_TOPUP   = 3'd1; // wait head taken, keep topping
  localparam logic [2:0] NX_PROMOTE = 3'd2; // retire then promote
  localparam logic [2:0] NX_APPRUN  = 3'd3; // rotate / wake: append to run
  localparam logic [2:0] NX_APPWAIT = 3'd4; // block: append to wait
  localparam logic [2:0] NX_PROMEND = 3'd5; // promoted after retire

  logic [4:0]  state_q, state_d;
  logic [1:0]  policy_q;
  logic [15:0] slice_q;
  logic [5:0]  cap_q, refill_q;
  logic [CW-1:0] run_n_q, run_n_d, wait_n_q, wait_n_d;
  logic [ID_BITS-1:0] next_q, next_d;

  logic [2:0]  mode_q;
  logic [15:0] burst_q, pid_q;
  logic [3:0]  prio_q;

  logic [1:0]  sort_pass_q, sort_pass_d;   // 0,1 pre (run,wait) 2,3 post
  logic        sq_q, sq_d;                 // queue selector: 0 run, 1 wait
  logic [CW-1:0] i_q, i_d, j_q, j_d, idx_q, idx_d;
  entry_t      key_q, key_d, hold_q, hold_d;
  logic [2:0]  nx_q, nx_d;

  result_t     res_q, res_d;
  result_t     out_q, out_d;
  logic        ovalid_q, ovalid_d;

  // RAM ports
  logic          r_we, w_we;
  logic [RA-1:0] r_wa, r_ra;
  logic [WA-1:0] w_wa, w_ra;
  entry_t        r_wd, w_wd, r_rd, w_rd;

  tqps_ram #(.WIDTH(EW), .DEPTH(RUN_DEPTH)) u_run_ram (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd),
    .raddr_i(r_ra), .rdata_o(r_rd)
  );
  tqps_ram #(.WIDTH(EW), .DEPTH(WAIT_DEPTH)) u_wait_ram (
    .clk_i, .we_i(w_we), .waddr_i(w_wa), .wdata_i(w_wd),
    .raddr_i(w_ra), .rdata_o(w_rd)
  );

  logic [CW-1:0] cap_eff;
  logic          in_acc;
  entry_t        rd_sel;
  logic [CW-1:0] cur_n;
  logic          key_first;

  assign cap_eff = (CMPW'(cap_q) > CMPW'(RUN_DEPTH)) ? CW'(RUN_DEPTH) : CW'(cap_q);
  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == S_IDLE) && !ovalid_q;
  assign rd_sel      = sq_q ? w_rd : r_rd;
  assign cur_n       = sq_q ? wait_n_q : run_n_q;

  // Shared compare: does key go ahead of rd_sel under the sorted policies
  always_comb begin
    key_first = 1'b0;
    case (policy_q)
      POL_PRIO: key_first = key_q.prio > rd_sel.prio;
      POL_SRT:  key_first = key_q.left < rd_sel.left;
      default:  key_first = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POL_FCFS;
      slice_q  <= 16'd1;
      cap_q    <= RUN_CAP_RST;
      refill_q <= REFILL_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POLICY:  policy_q <= cfg_data_i[1:0];
        REG_SLICE:   slice_q  <= cfg_data_i;
        REG_RUN_CAP: cap_q    <= cfg_data_i[5:0];
        REG_REFILL:  refill_q <= cfg_data_i[5:0];
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      run_n_q     <= '0;
      wait_n_q    <= '0;
      next_q      <= '0;
      ovalid_q    <= 1'b0;
      sort_pass_q <= '0;
      sq_q        <= 1'b0;
      nx_q        <= NX_NONE;
    end else begin
      state_q     <= state_d;
      run_n_q     <= run_n_d;
      wait_n_q    <= wait_n_d;
      next_q      <= next_d;
      ovalid_q    <= ovalid_d;
      sort_pass_q <= sort_pass_d;
      sq_q        <= sq_d;
      nx_q        <= nx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    idx_q  <= idx_d;
    key_q  <= key_d;
    hold_q <= hold_d;
    res_q  <= res_d;
    out_q  <= out_d;
    if (in_acc) begin
      mode_q  <= mode_i;
      burst_q <= burst_time_i;
      prio_q  <= priority_level_i;
      pid_q   <= proc_id_i;
    end
  end

  always_comb begin
    state_d = state_q; run_n_d = run_n_q; wait_n_d = wait_n_q; next_d = next_q;
    ovalid_d = ovalid_q && out_stall_i; sort_pass_d = sort_pass_q; sq_d = sq_q;
    i_d = i_q; j_d = j_q; idx_d = idx_q; key_d = key_q; hold_d = hold_q;
    nx_d = nx_q; res_d = res_q; out_d = out_q;
    r_we = 1'b0; w_we = 1'b0; r_wa = '0; w_wa = '0; r_wd = key_q; w_wd = key_q;
    r_ra = '0; w_ra = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          res_d = '0;
          sort_pass_d = 2'd0; sq_d = 1'b0; i_d = CW'(1);
          state_d = (policy_q[1]) ? S_SORT : S_DISP;
        end
      end
      // ---- stable insertion sort on queue sq_q -----------------------
      S_SORT: begin
        if (i_q >= cur_n) begin
          if (sort_pass_q[0]) begin
            state_d = sort_pass_q[1] ? S_HIDR : S_DISP;
          end else begin
            sort_pass_d = sort_pass_q + 2'd1; sq_d = 1'b1; i_d = CW'(1);
          end
        end else begin
          r_ra = RA'(i_q); w_ra = WA'(i_q); j_d = i_q;
          state_d = S_SRTK;
        end
      end
      S_SRTK: begin
        key_d = rd_sel;
        r_ra = RA'(j_q - 1'b1); w_ra = WA'(j_q - 1'b1);
        state_d = S_SRTC;
      end
      S_SRTR: begin
        r_ra = RA'(j_q - 1'b1); w_ra = WA'(j_q - 1'b1);
        state_d = S_SRTC;
      end
      S_SRTC: begin
        if (key_first) begin
          // shift j-1 up to j
          r_wa = RA'(j_q); w_wa = WA'(j_q); r_wd = rd_sel; w_wd = rd_sel;
          r_we = !sq_q; w_we = sq_q;
          j_d = j_q - 1'b1;
          if (j_q == CW'(1)) begin
            r_wa = RA'(j_q); w_wa = WA'(j_q);
            state_d = S_SRTW;
          end else begin
            state_d = S_SRTR;
          end
        end else begin
          r_wa = RA'(j_q); w_wa = WA'(j_q); r_wd = key_q; w_wd = key_q;
          r_we = !sq_q; w_we = sq_q;
          i_d = i_q + 1'b1;
          state_d = S_SORT;
        end
      end
      S_SRTW: begin
        r_wa = '0; w_wa = '0; r_wd = key_q; w_wd = key_q;
        r_we = !sq_q; w_we = sq_q;
        i_d = i_q + 1'b1;
        state_d = S_SORT;
      end
      // ---- dispatch on mode -----------------------------------------
      S_DISP: begin
        nx_d = NX_NONE;
        case (mode_q)
          MODE_TICK: begin
            if (run_n_q == '0) begin
              res_d.status = ST_RUN_EMPTY; state_d = S_POST;
            end else begin
              r_ra = '0; state_d = S_HEADR; // hold head before top-up
            end
          end
          MODE_CREATE: begin
            key_d.id = next_q + 1'b1; key_d.burst = burst_q;
            key_d.left = burst_q; key_d.prio = prio_q;
            if (run_n_q < cap_eff) begin
              sq_d = 1'b0; state_d = S_APP;
              next_d = next_q + 1'b1; res_d.new_id = 16'(next_q + 1'b1);
            end else if (wait_n_q < CW'(WAIT_DEPTH)) begin
              sq_d = 1'b1; state_d = S_APP;
              next_d = next_q + 1'b1; res_d.new_id = 16'(next_q + 1'b1);
            end else begin
              res_d.status = ST_Q_FULL; state_d = S_POST;
            end
          end
          MODE_BLOCK: begin
            if (run_n_q == '0) begin
              res_d.status = ST_RUN_EMPTY; state_d = S_POST;
            end else begin
              sq_d = 1'b0; idx_d = '0; state_d = S_FIND;
            end
          end
          MODE_WAKE: begin
            if (wait_n_q == '0) begin
              res_d.status = ST_WAIT_EMPT; state_d = S_POST;
            end else if (run_n_q >= cap_eff) begin
              res_d.status = ST_RUN_FULL; state_d = S_POST;
            end else begin
              sq_d = 1'b1; idx_d = '0; state_d = S_FIND;
            end
          end
          MODE_REMOVE: begin
            sq_d = 1'b0; idx_d = '0; state_d = S_FIND;
          end
          default: state_d = S_POST;
        endcase
      end
      // ---- linear search for proc_id --------------------------------
      S_FIND: begin
        if (idx_q >= cur_n) begin
          res_d.status = ST_NOT_FOUND; state_d = S_POST;
        end else begin
          r_ra = RA'(idx_q); w_ra = WA'(idx_q); state_d = S_FINDC;
        end
      end
      S_FINDC: begin
        if (rd_sel.id == ID_BITS'(pid_q)) begin
          hold_d = rd_sel;
          if (mode_q == MODE_BLOCK && wait_n_q >= CW'(WAIT_DEPTH)) begin
            res_d.status = ST_Q_FULL; state_d = S_POST;
          end else begin
            nx_d = (mode_q == MODE_BLOCK) ? NX_APPWAIT :
                   (mode_q == MODE_WAKE)  ? NX_APPRUN  : NX_NONE;
            state_d = S_SHR;
          end
        end else begin
          idx_d = idx_q + 1'b1; state_d = S_FIND;
        end
      end
      // ---- compaction: remove entry idx of queue sq_q ----------------
      S_SHR: begin
        if (idx_q + 1'b1 >= cur_n) begin
          if (sq_q) wait_n_d = wait_n_q - 1'b1;
          else      run_n_d  = run_n_q - 1'b1;
          state_d = S_APP;
          case (nx_q)
            NX_APPRUN:  begin sq_d = 1'b0; key_d = hold_q; end
            NX_APPWAIT: begin sq_d = 1'b1; key_d = hold_q; end
            NX_TOPUP:   sq_d = 1'b0;   // key_q already holds the wait head
            NX_PROMOTE: begin
              if (wait_n_q != '0) begin
                sq_d = 1'b1; idx_d = '0; w_ra = '0; nx_d = NX_PROMEND;
                state_d = S_TOPW;
              end else begin
                state_d = S_POST;
              end
            end
            NX_PROMEND: sq_d = 1'b0;   // key_q already holds the wait head
            default: state_d = S_POST;
          endcase
        end else begin
          r_ra = RA'(idx_q + 1'b1); w_ra = WA'(idx_q + 1'b1);
          state_d = S_SHW;
        end
      end
      S_SHW: begin
        r_wa = RA'(idx_q); w_wa = WA'(idx_q); r_wd = rd_sel; w_wd = rd_sel;
        r_we = !sq_q; w_we = sq_q;
        idx_d = idx_q + 1'b1; state_d = S_SHR;
      end
      S_APP: begin
        // append key at the tail of queue sq_q
        if (sq_q) begin
          w_wa = WA'(wait_n_q); w_we = 1'b1; wait_n_d = wait_n_q + 1'b1;
        end else begin
          r_wa = RA'(run_n_q); r_we = 1'b1; run_n_d = run_n_q + 1'b1;
        end
        state_d = (nx_q == NX_TOPUP) ? S_TOPR : S_POST;
      end
      // ---- tick: head held in hold_q, then top-up -------------------
      S_HEADR: begin
        hold_d = r_rd;
        nx_d = NX_TOPUP; state_d = S_TOPR;
      end
      S_TOPR: begin
        // hold_q keeps the charged head; key_q carries promoted entries
        if (CMPW'(refill_q) > CMPW'(run_n_q) &&
            run_n_q < CW'(RUN_DEPTH) && wait_n_q != '0) begin
          w_ra = '0; state_d = S_TOPW;
        end else begin
          state_d = S_HEADW;
        end
      end
      S_TOPW: begin
        key_d = w_rd;
        // remove wait head, then append to run
        sq_d = 1'b1; idx_d = '0;
        state_d = S_SHR;
        if (nx_q == NX_TOPUP) hold_d = hold_q;
      end
      S_HEADW: begin
        key_d = hold_q;
        key_d.left = (hold_q.left > slice_q) ? hold_q.left - slice_q : 16'd0;
        state_d = S_DONE;
        if (hold_q.left <= slice_q) begin
          res_d.retired = 1'b1; res_d.retired_id = 16'(hold_q.id);
        end
      end
      S_DONE: begin
        // apply charge result to the head of the run queue
        sq_d = 1'b0; idx_d = '0;
        if (res_q.retired) begin
          nx_d = NX_PROMOTE; state_d = S_SHR;
        end else if (policy_q == POL_RR && run_n_q > CW'(1)) begin
          hold_d = key_q; nx_d = NX_APPRUN; state_d = S_SHR;
        end else begin
          r_wa = '0; r_wd = key_q; r_we = 1'b1; nx_d = NX_NONE;
          state_d = S_POST;
        end
      end
      S_POST: begin
        nx_d = NX_NONE;
        if (policy_q[1]) begin
          sort_pass_d = 2'd2; sq_d = 1'b0; i_d = CW'(1); state_d = S_SORT;
        end else begin
          state_d = S_HIDR;
        end
      end
      S_HIDR: begin
        r_ra = '0; state_d = S_HIDW;
      end
      S_HIDW: begin
        // run head keeps being read at address 0 while the output is busy
        res_d.head_id = (run_n_q != '0) ? 16'(r_rd.id) : 16'd0;
        res_d.run_level = 6'(run_n_q); res_d.wait_level = 6'(wait_n_q);
        if (!ovalid_q || !out_stall_i) begin
          out_d = res_d;
          ovalid_d = 1'b1; state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o  = ovalid_q;
  assign status_o     = out_q.status;
  assign new_id_o     = out_q.new_id;
  assign retired_o    = out_q.retired;
  assign retired_id_o = out_q.retired_id;
  assign head_id_o    = out_q.head_id;
  assign run_level_o  = out_q.run_level;
  assign wait_level_o = out_q.wait_level;

endmodule

// ===== hw/rtl/tqps_checker.sv =====
`timescale 1ns / 1ps
module tqps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [5:0] run_level_o,
  input logic [5:0] wait_level_o
);

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("input open after a beat");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= 3'd5) else $error("bad status");

  a_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> run_level_o <= 6'd32 && wait_level_o <= 6'd32)
    else $error("level out of range");

endmodule

bind two_queue_process_scheduler_top tqps_checker u_tqps_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .status_o, .run_level_o, .wait_level_o
);

// ===== tb/two_queue_process_scheduler_top_tb.sv =====
`timescale 1ns / 1ps
module two_queue_process_scheduler_top_tb;
  import tqps_pkg::*;

  localparam int QDEPTH = 32;

  // One process entry as the scheduler keeps it
  typedef struct {
    logic [15:0] id;
    logic [15:0] burst;
    logic [15:0] left;
    logic [3:0]  prio;
  } proc_t;

  // One operation beat on the input channel
  typedef struct {
    logic [2:0]  mode;
    logic [15:0] burst;
    logic [3:0]  prio;
    logic [15:0] pid;
  } op_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  mode_i = '0;
  logic [15:0] burst_time_i = '0;
  logic [3:0]  priority_level_i = '0;
  logic [15:0] proc_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] new_id_o;
  logic        retired_o;
  logic [15:0] retired_id_o;
  logic [15:0] head_id_o;
  logic [5:0]  run_level_o;
  logic [5:0]  wait_level_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;

  two_queue_process_scheduler_top DUT (.*);

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // Scheduler shadow: both queues, occupancies, id counter and registers
  // ---------------------------------------------------------------------
  proc_t       sh_run[QDEPTH];
  proc_t       sh_wait[QDEPTH];
  int          sh_run_n;
  int          sh_wait_n;
  logic [15:0] sh_last_id;
  logic [1:0]  sh_policy;
  logic [15:0] sh_slice;
  logic [5:0]  sh_cap;
  logic [5:0]  sh_refill;

  function automatic bit runs_ahead(proc_t a, proc_t b);
    if (sh_policy == POL_PRIO) return a.prio > b.prio;
    if (sh_policy == POL_SRT) return a.left < b.left;
    return 1'b0;
  endfunction

  // Stable insertion sort; sel picks the wait queue
  function automatic void order_queue(bit sel);
    proc_t q[QDEPTH];
    proc_t t;
    int n;
    int j;
    if (sh_policy == POL_FCFS || sh_policy == POL_RR) return;
    n = sel ? sh_wait_n : sh_run_n;
    for (int i = 0; i < QDEPTH; i++) q[i] = sel ? sh_wait[i] : sh_run[i];
    for (int i = 1; i < n; i++) begin
      t = q[i];
      j = i;
      while (j > 0 && runs_ahead(t, q[j-1])) begin
        q[j] = q[j-1];
        j--;
      end
      q[j] = t;
    end
    for (int i = 0; i < QDEPTH; i++)
      if (sel) sh_wait[i] = q[i];
      else sh_run[i] = q[i];
  endfunction

  function automatic void drop_run(int at);
    for (int i = at; i < sh_run_n - 1; i++) sh_run[i] = sh_run[i+1];
    sh_run_n--;
  endfunction

  function automatic void drop_wait(int at);
    for (int i = at; i < sh_wait_n - 1; i++) sh_wait[i] = sh_wait[i+1];
    sh_wait_n--;
  endfunction

  function automatic void promote_head();
    sh_run[sh_run_n] = sh_wait[0];
    sh_run_n++;
    drop_wait(0);
  endfunction

  function automatic result_t schedule_step(op_t op);
    result_t r;
    proc_t   e;
    int      cap;
    int      at;
    r = '0;
    cap = (sh_cap < QDEPTH) ? int'(sh_cap) : QDEPTH;
    order_queue(1'b0);
    order_queue(1'b1);
    case (op.mode)
      MODE_TICK: begin
        if (sh_run_n == 0) begin
          r.status = ST_RUN_EMPTY;
        end else begin
          while (sh_run_n < sh_refill && sh_run_n < QDEPTH && sh_wait_n > 0) promote_head();
          sh_run[0].left = (sh_run[0].left > sh_slice) ? sh_run[0].left - sh_slice : 16'd0;
          if (sh_run[0].left == 0) begin
            r.retired = 1'b1;
            r.retired_id = sh_run[0].id;
            drop_run(0);
            if (sh_wait_n > 0) promote_head();
          end else if (sh_policy == POL_RR && sh_run_n > 1) begin
            e = sh_run[0];
            drop_run(0);
            sh_run[sh_run_n] = e;
            sh_run_n++;
          end
        end
      end
      MODE_CREATE: begin
        if (sh_run_n < cap || sh_wait_n < QDEPTH) begin
          sh_last_id = sh_last_id + 16'd1;
          e.id = sh_last_id;
          e.burst = op.burst;
          e.left = op.burst;
          e.prio = op.prio;
          if (sh_run_n < cap) begin
            sh_run[sh_run_n] = e;
            sh_run_n++;
          end else begin
            sh_wait[sh_wait_n] = e;
            sh_wait_n++;
          end
          r.new_id = sh_last_id;
        end else begin
          r.status = ST_Q_FULL;
        end
      end
      MODE_BLOCK: begin
        at = -1;
        for (int i = sh_run_n - 1; i >= 0; i--) if (sh_run[i].id == op.pid) at = i;
        if (sh_run_n == 0) r.status = ST_RUN_EMPTY;
        else if (at < 0) r.status = ST_NOT_FOUND;
        else if (sh_wait_n >= QDEPTH) r.status = ST_Q_FULL;
        else begin
          sh_wait[sh_wait_n] = sh_run[at];
          sh_wait_n++;
          drop_run(at);
        end
      end
      MODE_WAKE: begin
        at = -1;
        for (int i = sh_wait_n - 1; i >= 0; i--) if (sh_wait[i].id == op.pid) at = i;
        if (sh_wait_n == 0) r.status = ST_WAIT_EMPT;
        else if (sh_run_n >= cap) r.status = ST_RUN_FULL;
        else if (at < 0) r.status = ST_NOT_FOUND;
        else begin
          sh_run[sh_run_n] = sh_wait[at];
          sh_run_n++;
          drop_wait(at);
        end
      end
      MODE_REMOVE: begin
        at = -1;
        for (int i = sh_run_n - 1; i >= 0; i--) if (sh_run[i].id == op.pid) at = i;
        if (at < 0) r.status = ST_NOT_FOUND;
        else drop_run(at);
      end
      default: ;  // spare modes leave everything alone
    endcase
    order_queue(1'b0);
    order_queue(1'b1);
    r.head_id = (sh_run_n > 0) ? sh_run[0].id : 16'd0;
    r.run_level = 6'(sh_run_n);
    r.wait_level = 6'(sh_wait_n);
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus store, expected results, counters
  // ---------------------------------------------------------------------
  op_t     pending_ops[$];
  result_t expected_results[$];
  op_t     cur_op;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_requests = 0;
  int      hold_seen;
  int      hold_cnt;
  int      ops_sent = 0;
  int      results_seen = 0;
  int      retire_seen = 0;
  int      mismatches = 0;
  int      ids_made = 0;   // creates generated, used to aim proc_id at live ids

  // Driver: a beat leaves at a clean edge, stalled payload held steady
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(schedule_step(cur_op));
        ops_sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_op = pending_ops.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= cur_op.mode;
          burst_time_i <= cur_op.burst;
          priority_level_i <= cur_op.prio;
          proc_id_i <= cur_op.pid;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stalls plus an occasional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_seen <= 0;
      hold_cnt <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{status_o, new_id_o, retired_o, retired_id_o, head_id_o,
                run_level_o, wait_level_o};
        results_seen++;
        if (retired_o) retire_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected result beat %p", got);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.new_id !== want.new_id ||
              got.retired !== want.retired || got.retired_id !== want.retired_id ||
              got.head_id !== want.head_id || got.run_level !== want.run_level ||
              got.wait_level !== want.wait_level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d exp %p got %p", results_seen, want, got);
          end
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen <= hold_requests;
        hold_cnt <= 4000;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
      end
      out_stall_i <= (hold_cnt > 1) || ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic op_t make_op(logic [2:0] m, logic [15:0] b, logic [3:0] p,
                                  logic [15:0] id);
    op_t o;
    o.mode = m;
    o.burst = b;
    o.prio = p;
    o.pid = id;
    return o;
  endfunction

  // Random operation, mostly aimed at ids that are likely alive
  function automatic op_t random_op();
    op_t o;
    int  roll;
    roll = $urandom_range(99);
    if (roll < 36) o.mode = MODE_TICK;
    else if (roll < 66) o.mode = MODE_CREATE;
    else if (roll < 79) o.mode = MODE_BLOCK;
    else if (roll < 92) o.mode = MODE_WAKE;
    else if (roll < 97) o.mode = MODE_REMOVE;
    else o.mode = 3'($urandom_range(5, 7));
    if ($urandom_range(9) == 0) o.burst = 16'($urandom_range(1, 65535));
    else o.burst = 16'($urandom_range(1, 10));
    o.prio = 4'($urandom);
    if ($urandom_range(9) == 0) o.pid = 16'($urandom);
    else o.pid = 16'(ids_made - $urandom_range(0, 40));
    if (o.mode == MODE_CREATE) ids_made++;
    return o;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_POLICY:  sh_policy = val[1:0];
      REG_SLICE:   sh_slice = val;
      REG_RUN_CAP: sh_cap = val[5:0];
      default:     sh_refill = val[5:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid_i || expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Sequence: directed checks, then phases of settings and idling
  // ---------------------------------------------------------------------
  initial begin
    logic [1:0]  ph_pol[8];
    logic [15:0] ph_slice[8];
    logic [5:0]  ph_cap[8];
    logic [5:0]  ph_fill[8];
    int          idle_sel;

    ph_pol   = '{POL_FCFS, POL_RR, POL_PRIO, POL_SRT,
                 POL_RR, POL_PRIO, POL_SRT, POL_FCFS};
    ph_slice = '{16'd1, 16'd3, 16'd2, 16'd65535,
                 16'd1, 16'd4, 16'd1, 16'd65535};
    ph_cap   = '{6'd20, 6'd32, 6'd1, 6'd8, 6'd3, 6'd32, 6'd2, 6'd16};
    ph_fill  = '{6'd5, 6'd0, 6'd32, 6'd2, 6'd32, 6'd6, 6'd0, 6'd4};

    sh_run_n = 0;
    sh_wait_n = 0;
    sh_last_id = '0;
    sh_policy = POL_FCFS;
    sh_slice = 16'd1;
    sh_cap = RUN_CAP_RST;
    sh_refill = REFILL_RST;
    for (int i = 0; i < QDEPTH; i++) begin
      sh_run[i] = '{16'd0, 16'd0, 16'd0, 4'd0};
      sh_wait[i] = '{16'd0, 16'd0, 16'd0, 4'd0};
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-queue corners, spare modes, field extremes, ties
    pending_ops.push_back(make_op(MODE_TICK, 16'd1, 4'd0, 16'd0));
    pending_ops.push_back(make_op(MODE_BLOCK, 16'd1, 4'd0, 16'd1));
    pending_ops.push_back(make_op(MODE_WAKE, 16'd1, 4'd0, 16'd1));
    pending_ops.push_back(make_op(MODE_REMOVE, 16'd1, 4'd0, 16'd0));
    pending_ops.push_back(make_op(3'd7, 16'hFFFF, 4'hF, 16'hFFFF));
    pending_ops.push_back(make_op(3'd5, 16'd1, 4'd0, 16'd0));
    pending_ops.push_back(make_op(MODE_CREATE, 16'd1, 4'd0, 16'd0));
    pending_ops.push_back(make_op(MODE_CREATE, 16'hFFFF, 4'hF, 16'hFFFF));
    pending_ops.push_back(make_op(MODE_CREATE, 16'd2, 4'hF, 16'd0));
    pending_ops.push_back(make_op(MODE_REMOVE, 16'd1, 4'd0, 16'hFFFF)); // absent id
    pending_ops.push_back(make_op(MODE_BLOCK, 16'd1, 4'd0, 16'd2));
    pending_ops.push_back(make_op(MODE_WAKE, 16'd1, 4'd0, 16'd9));      // absent in wait
    pending_ops.push_back(make_op(MODE_TICK, 16'd1, 4'd0, 16'd0));      // retires id 1
    pending_ops.push_back(make_op(MODE_WAKE, 16'd1, 4'd0, 16'd2));
    pending_ops.push_back(make_op(MODE_BLOCK, 16'd1, 4'd0, 16'd2));
    pending_ops.push_back(make_op(MODE_REMOVE, 16'd1, 4'd0, 16'd3));
    pending_ops.push_back(make_op(MODE_TICK, 16'd1, 4'd0, 16'd0));      // run empty, wait holds id 2
    pending_ops.push_back(make_op(MODE_REMOVE, 16'd1, 4'd0, 16'd2));    // only in wait
    pending_ops.push_back(make_op(MODE_TICK, 16'd1, 4'd0, 16'd0));      // still empty, wait holds id 2
    ids_made = 3;
    wait_drained();

    // Tiny run capacity, then a tick with a large slice: saturation and
    // refill from the wait queue before the charge
    write_reg(REG_RUN_CAP, 16'd1);
    write_reg(REG_SLICE, 16'hFFFF);
    pending_ops.push_back(make_op(MODE_WAKE, 16'd1, 4'd0, 16'd2));
    pending_ops.push_back(make_op(MODE_CREATE, 16'd7, 4'd3, 16'd0));
    pending_ops.push_back(make_op(MODE_WAKE, 16'd1, 4'd0, 16'd4));      // run at capacity
    pending_ops.push_back(make_op(MODE_TICK, 16'd1, 4'd0, 16'd0));
    pending_ops.push_back(make_op(MODE_TICK, 16'd1, 4'd0, 16'd0));
    ids_made = 4;
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_POLICY, 16'(ph_pol[ph]));
      write_reg(REG_SLICE, ph_slice[ph]);
      write_reg(REG_RUN_CAP, 16'(ph_cap[ph]));
      write_reg(REG_REFILL, 16'(ph_fill[ph]));
      idle_sel = ph % 4;
      send_idle_pct = (idle_sel == 1) ? 46 : (idle_sel == 3) ? 24 : 0;
      recv_stall_pct = (idle_sel == 2) ? 46 : (idle_sel == 3) ? 24 : 0;
      for (int k = 0; k < 70; k++) pending_ops.push_back(random_op());
      if (ph == 2) hold_requests++;   // receiver holds off, input backs up
      // sender stands still until every result is back, then carries on
      while (in_valid_i || pending_ops.size() > 0 || expected_results.size() > 0)
        @(posedge clk_i);
      for (int k = 0; k < 70; k++) pending_ops.push_back(random_op());
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (2000) @(posedge clk_i);

    $display("Covered %0d operations over 8 settings and 4 idling mixes, %0d results",
             ops_sent, results_seen);
    $display("Retirements %0d, mismatches %0d, results left over %0d",
             retire_seen, mismatches, expected_results.size());
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS two_queue_process_scheduler_top");
    end else begin
      $display("FAIL two_queue_process_scheduler_top");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #400_000_000;
    $display("FAIL two_queue_process_scheduler_top");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tqps_pkg.sv
hw/rtl/tqps_ram.sv
hw/rtl/two_queue_process_scheduler_top.sv
hw/rtl/tqps_checker.sv
tb/two_queue_process_scheduler_top_tb.sv
